// ----- design/frs_pkg.sv -----
// ============================================================================
// frs_pkg: shared types and constants for the fitness roulette selector
// Item structs, controller command/status bundles and fixed-point constants.
// ============================================================================
package frs_pkg;

    localparam int unsigned FIT_W     = 33;   // unsigned Q17.16 fitness
    localparam int unsigned TOTAL_W   = 40;   // running fitness total
    localparam int unsigned VALUE_W   = 32;   // signed Q16.16 value
    localparam int unsigned FRAC_W    = 16;   // unsigned 0.16 fraction
    localparam int unsigned SEL_W     = 7;    // reported index width
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 32;

    localparam int unsigned MATCH_VALUE = 1000;
    localparam logic [FIT_W-1:0] FIT_MATCH = FIT_W'(MATCH_VALUE) << 16;

    // restoring division of 2^32 by the distance, one quotient bit per step
    localparam int unsigned DIV_STEPS = 33;
    localparam logic [5:0] DIV_FIRST = 6'(DIV_STEPS - 1);

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POP  = 1'd1;

    localparam logic [VALUE_W-1:0] GOAL_RESET = 32'd65536000;
    localparam logic [7:0]         POP_RESET  = 8'd100;

    typedef struct packed {
        logic                      command;
        logic                      first_of_generation;
        logic signed [VALUE_W-1:0] candidate_value;
        logic [FRAC_W-1:0]         random_fraction;
    } frs_in_t;

    typedef struct packed {
        logic [FIT_W-1:0] fitness_out;
        logic             goal_matched;
        logic [SEL_W-1:0] selected_index;
    } frs_out_t;

    typedef struct packed {
        logic capture;   // item accepted, latch its fields
        logic div_step;  // one restoring division step
        logic mul;       // form the slice, clear the walk
        logic walk;      // one stored entry per cycle
        logic finish;    // load result register, commit a load
    } frs_cmd_t;

    typedef struct packed {
        logic div_last;
        logic count_zero;
        logic walk_done;
    } frs_sts_t;

endpackage

// ----- design/fitness_roulette_selector.sv -----
// ============================================================================
// fitness_roulette_selector: fitness store with roulette-wheel selection
// Top level: controller, datapath and fitness store.
// ============================================================================
// One item is in flight at a time; the input stalls until its result is in
// the output register, and the next item may enter while that result still
// waits to be taken. A load runs a restoring divider, one quotient bit per
// cycle. A select forms the slice in the multiply state and then walks the
// fitness store one entry per cycle through its registered read port; when
// the population count is zero it skips the walk. Entries never written
// since reset give undefined picks.
// ============================================================================
module fitness_roulette_selector
    import frs_pkg::*;
#(
    parameter int unsigned POP_MAX = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  frs_in_t              in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output frs_out_t             out_item,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    frs_cmd_t cmd;
    frs_sts_t sts;

    frs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_item.command),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    frs_datapath #(
        .POP_MAX (POP_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_item)
    );

endmodule

// ----- design/frs_ram.sv -----
// ============================================================================
// frs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module frs_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/frs_ctrl.sv -----
// ============================================================================
// frs_ctrl: sequencing state machine
// Accepts one item at a time, steps the divider or the roulette walk,
// and hands the result to the output register.
// ============================================================================
module frs_ctrl
    import frs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_command,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output frs_cmd_t cmd,
    input  frs_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_WALK,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.capture  = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_command == CMD_SELECT) ? S_MUL : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = sts.count_zero ? S_FIN : S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.finish)
        else $error("result overwritten while stalled");

    // an accepted item closes the input in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input open right after accept");

    // a new result shows up only from the finishing state
    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result valid without finish");
`endif

endmodule

// ----- design/frs_datapath.sv -----
// ============================================================================
// frs_datapath: fitness divider, fitness store and roulette walk
// Holds the configuration, the running total, the serial divider and the
// select accumulator; steered by the controller's commands.
// ============================================================================
module frs_datapath
    import frs_pkg::*;
#(
    parameter int unsigned POP_MAX = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  frs_in_t              in_item,
    input  frs_cmd_t             cmd,
    output frs_sts_t             sts,
    output frs_out_t             out_item
);

    localparam int unsigned IDXW = $clog2(POP_MAX);
    localparam int unsigned CNTW = IDXW + 1;
    localparam int unsigned CW   = (CNTW > 8) ? CNTW : 8;
    localparam int unsigned SW   = FIT_W + IDXW;
    localparam int unsigned CMPW = (SW > TOTAL_W) ? SW : TOTAL_W;
    localparam int unsigned PW   = (IDXW > SEL_W) ? IDXW : SEL_W;
    localparam int unsigned PRODW = FRAC_W + TOTAL_W;

    // configuration
    logic [VALUE_W-1:0] goal_reg;
    logic [7:0]         pop_reg;

    // control state
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNTW-1:0]    widx_reg, widx_next;

    // captured item
    logic                 is_select_reg;
    logic                 first_reg;
    logic [FRAC_W-1:0]    frac_reg;

    // divider
    logic [FIT_W-1:0]   dvs_reg;
    logic [FIT_W-1:0]   rem_reg;
    logic [FIT_W-1:0]   quo_reg;
    logic [5:0]         dcnt_reg;
    logic               matched_reg;
    logic signed [VALUE_W:0] diff;
    logic [FIT_W-1:0]   distance;
    logic [FIT_W:0]     rem_sh;
    logic               rem_ge;

    // walk
    logic [TOTAL_W-1:0] slice_reg;
    logic [SW-1:0]      sum_reg;
    logic [SW-1:0]      sum_next;
    logic [CNTW-1:0]    raddr_reg;
    logic [IDXW-1:0]    chk_idx_reg;
    logic               chk_v_reg;
    logic [IDXW-1:0]    pick_reg;
    logic [PW-1:0]      pick_ext;
    logic [PRODW-1:0]   prod;
    logic [CW-1:0]      pop_ext;
    logic [CW-1:0]      count_w;
    logic [CNTW-1:0]    count;
    logic               hit;
    logic               last;

    // commit
    logic [FIT_W-1:0]   fit;
    logic [TOTAL_W-1:0] base_total;
    logic [CNTW-1:0]    base_widx;
    logic [TOTAL_W:0]   total_sum;
    logic               store_we;
    logic [FIT_W-1:0]   rdata;

    frs_out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg <= GOAL_RESET;
            pop_reg  <= POP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GOAL: goal_reg <= cfg_data;
                REG_POP:  pop_reg  <= cfg_data[7:0];
                default:  ;
            endcase
        end
    end

    // distance to the goal, 1 .. 2^32 - 1 unless matched
    assign diff = (VALUE_W+1)'(signed'(goal_reg)) - (VALUE_W+1)'(in_item.candidate_value);
    assign distance = diff[VALUE_W] ? FIT_W'(-diff) : FIT_W'(diff);

    // numerator is 2^32: a single one at the first step
    assign rem_sh = {rem_reg, (dcnt_reg == DIV_FIRST)};
    assign rem_ge = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_select_reg <= in_item.command;
            first_reg     <= in_item.first_of_generation;
            frac_reg      <= in_item.random_fraction;
            matched_reg   <= (diff == '0);
            dvs_reg       <= distance;
            rem_reg       <= '0;
            quo_reg       <= '0;
            dcnt_reg      <= DIV_FIRST;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? FIT_W'(rem_sh - {1'b0, dvs_reg}) : FIT_W'(rem_sh);
            quo_reg  <= {quo_reg[FIT_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg - 6'd1;
        end
    end

    assign sts.div_last = (dcnt_reg == '0);

    // population clamp
    assign pop_ext = CW'(pop_reg);
    assign count_w = (pop_ext > CW'(POP_MAX)) ? CW'(POP_MAX) : pop_ext;
    assign count   = count_w[CNTW-1:0];
    assign sts.count_zero = (count == '0);

    assign prod     = PRODW'(frac_reg) * PRODW'(total_reg);
    assign sum_next = sum_reg + SW'(rdata);
    assign hit      = (CMPW'(sum_next) >= CMPW'(slice_reg));
    assign last     = ((CNTW'(chk_idx_reg) + CNTW'(1)) == count);
    assign sts.walk_done = chk_v_reg && (hit || last);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            slice_reg <= prod[PRODW-1:FRAC_W];
            sum_reg   <= '0;
            raddr_reg <= '0;
            chk_v_reg <= 1'b0;
            pick_reg  <= '0;
        end
        else if (cmd.walk)
        begin
            chk_v_reg   <= (raddr_reg < count);
            chk_idx_reg <= raddr_reg[IDXW-1:0];
            if (raddr_reg < count)
            begin
                raddr_reg <= raddr_reg + CNTW'(1);
            end
            if (chk_v_reg)
            begin
                sum_reg <= sum_next;
            end
            if (sts.walk_done)
            begin
                pick_reg <= chk_idx_reg;
            end
        end
    end

    // load commit
    assign fit        = matched_reg ? FIT_MATCH : quo_reg;
    assign base_total = first_reg ? '0 : total_reg;
    assign base_widx  = first_reg ? '0 : widx_reg;
    assign store_we   = cmd.finish && !is_select_reg && (base_widx < CNTW'(POP_MAX));
    assign total_sum  = {1'b0, base_total} + (TOTAL_W+1)'(fit);

    always_comb
    begin
        total_next = total_reg;
        widx_next  = widx_reg;
        if (cmd.finish && !is_select_reg)
        begin
            total_next = base_total;
            widx_next  = base_widx;
            if (store_we)
            begin
                total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                widx_next  = base_widx + CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            widx_reg  <= '0;
        end
        else
        begin
            total_reg <= total_next;
            widx_reg  <= widx_next;
        end
    end

    frs_ram #(
        .WIDTH (FIT_W),
        .DEPTH (POP_MAX)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (base_widx[IDXW-1:0]),
        .wdata (fit),
        .raddr (raddr_reg[IDXW-1:0]),
        .rdata (rdata)
    );

    assign pick_ext = PW'(pick_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (is_select_reg)
            begin
                out_reg.fitness_out    <= '0;
                out_reg.goal_matched   <= 1'b0;
                out_reg.selected_index <= pick_ext[SEL_W-1:0];
            end
            else
            begin
                out_reg.fitness_out    <= fit;
                out_reg.goal_matched   <= matched_reg;
                out_reg.selected_index <= '0;
            end
        end
    end

    assign out_item = out_reg;

`ifndef SYNTH
    a_widx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        widx_reg <= CNTW'(POP_MAX))
        else $error("write index beyond store depth");

    // restoring division keeps the partial remainder below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !matched_reg) |=> (rem_reg < dvs_reg))
        else $error("divider remainder out of range");

    // the walk never checks an entry past the population
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && chk_v_reg) |-> (CNTW'(chk_idx_reg) < count))
        else $error("walk past population");
`endif

endmodule
